FILE: sv/bfha_pkg.sv
package bfha_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,
        S_SCAN,
        S_ASPL,
        S_AFIN,
        S_FSCAN,
        S_FMRG,
        S_SHUP,
        S_SHDN,
        S_DONE
    } t_state;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

FILE: sv/best_fit_heap_allocator_core.sv
// Best-fit heap allocator core.
//
// Channels: an item (alloc or free request) is taken at a rising edge where
// start is high and busy is low. The single result, o_status, shows for
// exactly one cycle with o_done high; the receiver cannot hold it off.
// Configuration: i_cfg_valid/o_cfg_ready write the fragmentation mode bit;
// o_cfg_ready is high whenever the core is idle.
//
// Sequencing: one item at a time; the next item can be taken in the o_done cycle.
// With N live blocks an alloc walks all N entries through the block memory
// read port; a split then shifts the entries above the chosen block up one
// slot, one per cycle. A free walks the entries up to its target, then the
// upper entries shift down one slot per merge, one per cycle. The one-read,
// one-write block memory sets the pace. A zero or oversize alloc skips the scan.
//
// Reset: synchronous, active low. The heap comes up as one free block of
// HEAP_BYTES - HEADER_BYTES at entry 0; entries at or above r_count are never
// used, so the memory needs no clearing pass.
module best_fit_heap_allocator_core
    import bfha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_BLOCKS   = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [$clog2(HEAP_BYTES):0]   i_request_size,
    input  logic [$clog2(HEAP_BYTES)-1:0] i_free_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output logic                          o_done,
    output logic [1:0]                    o_status
);

    localparam int SW = $clog2(HEAP_BYTES) + 1;   // size width
    localparam int AW = $clog2(MAX_BLOCKS);       // index width
    localparam int CW = AW + 1;                   // count width
    localparam int PW = SW + 1;                   // position/compare width
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [PW-1:0] HDR = PW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    // Block memory: {free, size}. Entries at or above r_count are dead.
    logic [SW:0] mem [MAX_BLOCKS];
    logic [SW:0] rdata;
    logic [AW-1:0] raddr, waddr;
    logic [SW:0] wdata;
    logic we;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_free_bytes, n_free_bytes;
    logic r_mode;
    logic r_init, n_init;              // entry 0 not yet written since reset
    logic r_type;
    logic [SW-1:0] r_rsize, n_rsize;
    logic [SW-1:0] r_req;
    logic [SW-2:0] r_addr;
    logic [CW-1:0] r_k, n_k;           // scan / shift index
    logic [AW-1:0] r_best, n_best;
    logic [SW-1:0] r_bsize, n_bsize;
    logic r_found, n_found;
    logic [PW-1:0] r_pos, n_pos;
    logic [SW:0] r_prev, n_prev;       // entry k-1
    logic [SW:0] r_cur, n_cur;         // target / merged entry
    logic [AW-1:0] r_tgt, n_tgt;
    logic [CW-1:0] r_stop, n_stop;     // shift end
    logic r_merge_hi, n_merge_hi;      // pending upper merge after shift
    logic [1:0] r_status, n_status;
    logic r_done, n_done;

    logic [AW-1:0] r_raddr;

    logic [SW:0] ent;
    logic fits;
    logic [PW-1:0] need;
    always_comb begin
        ent = (r_init && r_raddr == '0) ? {1'b1, INIT_SIZE} : rdata;
        need = PW'(r_rsize) + HDR + PW'(2);
        if (r_mode) fits = ent[SW-1:0] >= r_rsize;
        else fits = (ent[SW-1:0] == r_rsize) || (PW'(ent[SW-1:0]) >= need);
    end

    // Control and datapath sequencing.
    always_comb begin
        n_state = r_state;
        n_count = r_count; n_free_bytes = r_free_bytes; n_init = r_init;
        n_rsize = r_rsize; n_k = r_k; n_best = r_best; n_bsize = r_bsize;
        n_found = r_found; n_pos = r_pos; n_prev = r_prev; n_cur = r_cur;
        n_tgt = r_tgt; n_stop = r_stop; n_merge_hi = r_merge_hi;
        n_status = r_status; n_done = 1'b0;
        raddr = r_k[AW-1:0]; we = 1'b0; waddr = '0; wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (start) begin
                    n_state = S_ARD; n_k = '0; n_found = 1'b0;
                    n_pos = '0;
                end
            end
            S_ARD: begin
                // check request, issue first read of entry 0
                raddr = '0; n_k = CW'(1);
                n_rsize = (r_req + SW'(1)) & ~SW'(1);
                if (r_type == REQ_ALLOC) begin
                    if (r_req == '0 || r_req > r_free_bytes) begin
                        n_status = ST_NOFIT; n_state = S_DONE;
                    end else n_state = S_SCAN;
                end else begin
                    n_prev = '0; n_state = S_FSCAN;
                end
            end
            S_SCAN: begin
                // rdata holds entry r_k-1
                if (ent[SW] && fits && (!r_found || ent[SW-1:0] < r_bsize)) begin
                    n_found = 1'b1; n_best = r_raddr; n_bsize = ent[SW-1:0];
                end
                n_k = r_k + CW'(1);
                if (r_k >= r_count) begin
                    n_state = S_ASPL;
                end
            end
            S_ASPL: begin
                if (!r_found) begin
                    n_status = ST_NOFIT; n_state = S_DONE;
                end else if (PW'(r_bsize) >= need && r_count < MAXC) begin
                    // shift entries [best+1, count-1] up by one, top first
                    n_k = r_count; n_stop = CW'(r_best) + CW'(2);
                    n_cur = {1'b1, SW'(PW'(r_bsize) - PW'(r_rsize) - HDR)};
                    n_free_bytes = r_free_bytes - SW'(HEADER_BYTES) - r_rsize;
                    n_count = r_count + CW'(1);
                    raddr = r_count[AW-1:0] - AW'(1);
                    we = 1'b1; waddr = r_best; wdata = {1'b0, r_rsize};
                    if (r_best == '0) n_init = 1'b0;
                    n_merge_hi = 1'b0;
                    n_tgt = r_best + AW'(1);
                    n_state = S_SHUP;
                end else begin
                    we = 1'b1; waddr = r_best; wdata = {1'b0, r_bsize};
                    if (r_best == '0) n_init = 1'b0;
                    n_free_bytes = r_free_bytes - r_bsize;
                    n_status = ST_OK; n_state = S_DONE;
                end
            end
            S_SHUP: begin
                // mem[k] <= mem[k-1], moving downward; then place new entry
                if (r_k >= r_stop) begin
                    raddr = r_k[AW-1:0] - AW'(2);
                    we = 1'b1; waddr = r_k[AW-1:0]; wdata = ent;
                    n_k = r_k - CW'(1);
                end else begin
                    we = 1'b1; waddr = r_tgt; wdata = r_cur;
                    n_status = ST_OK; n_state = S_DONE;
                end
            end
            S_FSCAN: begin
                // ent is entry r_k-1 at offset r_pos
                if (r_k > r_count) begin
                    n_status = ST_BADFREE; n_state = S_DONE;
                end else if (r_pos + HDR == PW'(r_addr)) begin
                    if (ent[SW]) begin
                        n_status = ST_BADFREE; n_state = S_DONE;
                    end else begin
                        n_tgt = r_raddr; n_cur = {1'b1, ent[SW-1:0]};
                        n_free_bytes = r_free_bytes + ent[SW-1:0];
                        raddr = r_k[AW-1:0];
                        n_state = S_FMRG;
                    end
                end else begin
                    n_prev = ent;
                    n_pos = r_pos + HDR + PW'(ent[SW-1:0]);
                    n_k = r_k + CW'(1);
                end
            end
            S_FMRG: begin
                // ent = entry tgt+1 (valid if tgt+1 < count)
                if (r_tgt != '0 && r_prev[SW]) begin
                    // merge into lower neighbour, then maybe upper
                    n_cur = {1'b1, SW'(PW'(r_prev[SW-1:0]) + HDR + PW'(r_cur[SW-1:0]))};
                    n_free_bytes = r_free_bytes + SW'(HEADER_BYTES);
                    n_tgt = r_tgt - AW'(1);
                    n_merge_hi = (CW'(r_tgt) + CW'(1) < r_count) && ent[SW];
                    if (n_merge_hi) begin
                        n_cur = {1'b1, SW'(PW'(r_prev[SW-1:0]) + HDR + PW'(r_cur[SW-1:0])
                                 + HDR + PW'(ent[SW-1:0]))};
                        n_free_bytes = r_free_bytes + SW'(2 * HEADER_BYTES);
                    end
                end else if ((CW'(r_tgt) + CW'(1) < r_count) && ent[SW]) begin
                    n_merge_hi = 1'b1;
                    n_cur = {1'b1, SW'(PW'(r_cur[SW-1:0]) + HDR + PW'(ent[SW-1:0]))};
                    n_free_bytes = r_free_bytes + SW'(HEADER_BYTES);
                end else begin
                    n_merge_hi = 1'b0;
                end
                // removed slots: shift down by n removed
                we = 1'b1; waddr = n_tgt; wdata = n_cur;
                if (n_tgt == '0) n_init = 1'b0;
                n_k = CW'(n_tgt) + CW'(1);
                if (n_tgt != r_tgt || n_merge_hi) begin
                    n_stop = (n_tgt != r_tgt && n_merge_hi) ? CW'(2) : CW'(1);
                    n_count = r_count - n_stop;
                    raddr = AW'(CW'(n_tgt) + CW'(1) + n_stop);
                    n_state = S_SHDN;
                end else begin
                    n_status = ST_OK; n_state = S_DONE;
                end
            end
            S_SHDN: begin
                // mem[k] <= mem[k+stop]
                if (r_k < r_count) begin
                    we = 1'b1; waddr = r_k[AW-1:0]; wdata = ent;
                    raddr = AW'(r_k + CW'(1) + r_stop);
                    n_k = r_k + CW'(1);
                end else begin
                    n_status = ST_OK; n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= CW'(1); r_free_bytes <= INIT_SIZE;
            r_mode <= 1'b0; r_init <= 1'b1; r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_free_bytes <= n_free_bytes;
            r_init <= n_init; r_done <= n_done;
            if (i_cfg_valid && o_cfg_ready) r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_type <= i_req_type; r_req <= i_request_size; r_addr <= i_free_address;
        end
        r_raddr <= raddr;
        r_rsize <= n_rsize; r_k <= n_k; r_best <= n_best; r_bsize <= n_bsize;
        r_found <= n_found; r_pos <= n_pos; r_prev <= n_prev; r_cur <= n_cur;
        r_tgt <= n_tgt; r_stop <= n_stop; r_merge_hi <= n_merge_hi;
        r_status <= n_status;
    end

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done = r_done;
    assign o_status = r_status;

endmodule

FILE: sv/bfha_checker.sv
module bfha_checker
    import bfha_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status
);
    a_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_NOFIT ||
                    o_status == ST_BADFREE)) else $error("bad status");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_status(o_status)
);
